### hdl/twcs_pkg.sv
`default_nettype none
package twcs_pkg;

   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_SHADE_ENABLE    = 2'd0;
   localparam csr_idx_type CSR_SHADE_STRENGTH  = 2'd1;
   localparam csr_idx_type CSR_TEXTURE_PRESENT = 2'd2;

   localparam int CSR_DATA_W = 16;
   localparam logic [15:0] STRENGTH_RESET = 16'd256;

   // Shading works on a 17.16 denominator whose unit is 65536.
   localparam int DEN_W = 33;
   localparam logic [DEN_W-1:0] DEN_ONE = 33'h0_0001_0000;
   localparam int SHADE_QB = 16;

endpackage
`default_nettype wire

### hdl/twcs_frac_div.sv
`default_nettype none
module twcs_frac_div #(
   parameter int N = 8,
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         enable,
   input  logic [W-1:0] a,
   input  logic [W-1:0] d,
   output logic [N-1:0] q
);

   // Gives floor(a * 2**N / d) for a < d, one quotient bit per stage.
   logic [W-1:0] r_ff [N];
   logic [W-1:0] d_ff [N];
   logic [N-1:0] q_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [W-1:0] r_prev;
      logic [W-1:0] d_prev;
      logic [N-1:0] q_prev;
      logic [W:0]   r2;
      logic         bit_q;
      logic [W-1:0] r_in;

      if (i == 0) begin : g_first
         assign r_prev = a;
         assign d_prev = d;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[i-1];
         assign d_prev = d_ff[i-1];
         assign q_prev = q_ff[i-1];
      end

      always_comb begin
         r2    = {r_prev, 1'b0};
         bit_q = (r2 >= {1'b0, d_prev});
         r_in  = bit_q ? W'(r2 - {1'b0, d_prev}) : W'(r2);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[i] <= r_in;
            d_ff[i] <= d_prev;
            q_ff[i] <= N'({q_prev, bit_q});
         end
      end
   end

   assign q = q_ff[N-1];

endmodule
`default_nettype wire

### hdl/textured_wall_column_shader.sv
// Textured wall column shader.
// The req channel carries one beat per item: action 0 writes texel_value into
// the texel memory at (tex_sel, texel_row, texel_col); action 1 shades one
// wall pixel and yields one rsp beat with pixel_x, pixel_y and pixel_color.
// Writes yield no rsp beat. Items leave in the order they arrive.
// One item is accepted every cycle unless req_stall is high. A shade beat passes
// through the capture, numerator, texture row divider, texel memory, colour,
// shading divider and output stages on its way to rsp.
// The texel memory is a single port RAM; writes and reads pass its stage in
// item order, so a shade item always sees every earlier write.
// Reset empties the pipeline and loads the register defaults; the texel
// memory keeps its contents and holds nothing defined until written.
// When rsp_stall is high with a beat waiting, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is lost or repeated.
// The csr port is written only while the block is idle; the user is bound to this, the block does not enforce it.
`default_nettype none
module textured_wall_column_shader #(
   parameter int TEX_SIZE      = 64,
   parameter int SCREEN_HEIGHT = 512,
   parameter int TEXTURE_COUNT = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_action,
   input  logic [1:0]                 req_tex_sel,
   input  logic [5:0]                 req_texel_col,
   input  logic [5:0]                 req_texel_row,
   input  logic [31:0]                req_texel_value,
   input  logic [9:0]                 req_screen_x,
   input  logic [8:0]                 req_screen_y,
   input  logic [15:0]                req_wall_height,
   input  logic [15:0]                req_wall_dist,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [9:0]                 rsp_pixel_x,
   output logic [8:0]                 rsp_pixel_y,
   output logic [31:0]                rsp_pixel_color,
   input  logic                       csr_wr_en,
   input  twcs_pkg::csr_idx_type      csr_index,
   input  logic [twcs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import twcs_pkg::*;

   localparam int TEXB   = $clog2(TEX_SIZE);
   localparam int TIB    = (TEXTURE_COUNT > 1) ? $clog2(TEXTURE_COUNT) : 1;
   localparam int ADDR_W = TIB + 2 * TEXB;
   localparam int DEPTH  = TEXTURE_COUNT * TEX_SIZE * TEX_SIZE;
   localparam int HALF   = SCREEN_HEIGHT / 2;
   localparam int NUM_W  = 17;

   typedef struct packed {
      logic            v;
      logic            act;
      logic [2:0]      tex;
      logic [TEXB-1:0] col;
      logic [TEXB-1:0] roww;
      logic            wok;
      logic [31:0]     val;
      logic [9:0]      x;
      logic [8:0]      y;
      logic            ge;
      logic [31:0]     prod;
   } row_side_type;

   typedef struct packed {
      logic        v;
      logic [9:0]  x;
      logic [8:0]  y;
      logic [31:0] color;
   } shade_side_type;

   logic        shade_en_ff;
   logic [15:0] strength_ff;
   logic [3:0]  present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shade_en_ff <= 1'b0;
         strength_ff <= STRENGTH_RESET;
         present_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SHADE_ENABLE:    shade_en_ff <= csr_wdata[0];
            CSR_SHADE_STRENGTH:  strength_ff <= csr_wdata[15:0];
            CSR_TEXTURE_PRESENT: present_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Capture stage.
   logic            va_ff;
   logic            act_a_ff;
   logic [2:0]      tex_a_ff;
   logic [TEXB-1:0] col_a_ff;
   logic [TEXB-1:0] row_a_ff;
   logic            wok_a_ff;
   logic [31:0]     val_a_ff;
   logic [9:0]      x_a_ff;
   logic [8:0]      y_a_ff;
   logic [15:0]     wh_a_ff;
   logic [15:0]     dist_a_ff;

   logic [7:0]      col8;
   logic [7:0]      row8;
   logic [7:0]      col_cl;
   logic            wok_in;

   always_comb begin
      col8   = 8'(req_texel_col);
      row8   = 8'(req_texel_row);
      col_cl = (9'(col8) > 9'(TEX_SIZE - 1)) ? 8'(TEX_SIZE - 1) : col8;
      wok_in = (4'(req_tex_sel) < 4'(TEXTURE_COUNT)) &&
               (9'(col8) < 9'(TEX_SIZE)) && (9'(row8) < 9'(TEX_SIZE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act_a_ff  <= req_action;
         tex_a_ff  <= 3'(req_tex_sel);
         col_a_ff  <= col_cl[TEXB-1:0];
         row_a_ff  <= row8[TEXB-1:0];
         wok_a_ff  <= wok_in;
         val_a_ff  <= req_texel_value;
         x_a_ff    <= req_screen_x;
         y_a_ff    <= req_screen_y;
         wh_a_ff   <= (req_wall_height == 16'd0) ? 16'd1 : req_wall_height;
         dist_a_ff <= req_wall_dist;
      end
   end

   // Row numerator and distance product.
   logic [17:0]      sum_b;
   logic             neg_b;
   logic [NUM_W-1:0] num_in;
   logic [NUM_W-1:0] num_b_ff;
   logic [NUM_W-1:0] whd_b_ff;
   row_side_type     side_in;
   row_side_type     side_b_ff;

   always_comb begin
      sum_b  = 18'(y_a_ff) + 18'(wh_a_ff[15:1]);
      neg_b  = sum_b < 18'(HALF);
      num_in = neg_b ? '0 : NUM_W'(sum_b - 18'(HALF));
      side_in.v    = va_ff;
      side_in.act  = act_a_ff;
      side_in.tex  = tex_a_ff;
      side_in.col  = col_a_ff;
      side_in.roww = row_a_ff;
      side_in.wok  = wok_a_ff;
      side_in.val  = val_a_ff;
      side_in.x    = x_a_ff;
      side_in.y    = y_a_ff;
      side_in.ge   = num_in >= NUM_W'(wh_a_ff);
      side_in.prod = dist_a_ff * strength_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff.v <= 1'b0;
      end else if (adv) begin
         side_b_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_b_ff <= num_in;
         whd_b_ff <= NUM_W'(wh_a_ff);
      end
   end

   // Texture row divider.
   logic [TEXB-1:0] q_row;
   row_side_type    sd_ff [TEXB];

   twcs_frac_div #(.N(TEXB), .W(NUM_W)) u_row_div (
      .clock  (clock),
      .enable (adv),
      .a      (num_b_ff),
      .d      (whd_b_ff),
      .q      (q_row)
   );

   for (genvar i = 0; i < TEXB; i++) begin : g_row_side
      row_side_type prev_sd;
      if (i == 0) begin : g_first
         assign prev_sd = side_b_ff;
      end else begin : g_next
         assign prev_sd = sd_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[i].v <= 1'b0;
         end else if (adv) begin
            sd_ff[i] <= prev_sd;
         end
      end
   end

   // Texel memory stage.
   row_side_type     sm;
   logic [TEXB-1:0]  row_m;
   logic [ADDR_W-1:0] addr_m;
   logic             ok_in;

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_ff;
   logic             vm_ff;
   logic             ok_m_ff;
   logic [9:0]       x_m_ff;
   logic [8:0]       y_m_ff;
   logic [DEN_W-1:0] den_m_ff;

   always_comb begin
      sm     = sd_ff[TEXB-1];
      row_m  = sm.ge ? TEXB'(TEX_SIZE - 1) : q_row;
      addr_m = sm.act ? {sm.tex[TIB-1:0], row_m, sm.col}
                      : {sm.tex[TIB-1:0], sm.roww, sm.col};
      ok_in  = (4'(sm.tex) < 4'(TEXTURE_COUNT)) && present_ff[sm.tex[1:0]];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sm.v && !sm.act && sm.wok) begin
            mem[addr_m] <= sm.val;
         end
         rd_ff <= mem[addr_m];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= sm.v && sm.act;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok_m_ff  <= ok_in;
         x_m_ff   <= sm.x;
         y_m_ff   <= sm.y;
         den_m_ff <= DEN_ONE + DEN_W'(sm.prod);
      end
   end

   // Colour stage.
   logic             vc_ff;
   logic [31:0]      color_c_ff;
   logic [9:0]       x_c_ff;
   logic [8:0]       y_c_ff;
   logic [DEN_W-1:0] den_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         color_c_ff <= ok_m_ff ? rd_ff : 32'd0;
         x_c_ff     <= x_m_ff;
         y_c_ff     <= y_m_ff;
         den_c_ff   <= den_m_ff;
      end
   end

   // Shading dividers, one per channel.
   logic [SHADE_QB-1:0] q_r;
   logic [SHADE_QB-1:0] q_g;
   logic [SHADE_QB-1:0] q_b;
   shade_side_type      sc_ff [SHADE_QB];

   twcs_frac_div #(.N(SHADE_QB), .W(DEN_W)) u_div_r (
      .clock  (clock),
      .enable (adv),
      .a      (DEN_W'(color_c_ff[23:16])),
      .d      (den_c_ff),
      .q      (q_r)
   );

   twcs_frac_div #(.N(SHADE_QB), .W(DEN_W)) u_div_g (
      .clock  (clock),
      .enable (adv),
      .a      (DEN_W'(color_c_ff[15:8])),
      .d      (den_c_ff),
      .q      (q_g)
   );

   twcs_frac_div #(.N(SHADE_QB), .W(DEN_W)) u_div_b (
      .clock  (clock),
      .enable (adv),
      .a      (DEN_W'(color_c_ff[7:0])),
      .d      (den_c_ff),
      .q      (q_b)
   );

   for (genvar i = 0; i < SHADE_QB; i++) begin : g_shade_side
      shade_side_type prev_sc;
      if (i == 0) begin : g_first
         assign prev_sc = {vc_ff, x_c_ff, y_c_ff, color_c_ff};
      end else begin : g_next
         assign prev_sc = sc_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sc_ff[i].v <= 1'b0;
         end else if (adv) begin
            sc_ff[i] <= prev_sc;
         end
      end
   end

   // Output register.
   logic [9:0]  x_o_ff;
   logic [8:0]  y_o_ff;
   logic [31:0] color_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sc_ff[SHADE_QB-1].v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_o_ff     <= sc_ff[SHADE_QB-1].x;
         y_o_ff     <= sc_ff[SHADE_QB-1].y;
         color_o_ff <= shade_en_ff ? {8'h00, q_r[7:0], q_g[7:0], q_b[7:0]}
                                   : sc_ff[SHADE_QB-1].color;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = x_o_ff;
   assign rsp_pixel_y     = y_o_ff;
   assign rsp_pixel_color = color_o_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_shade_top_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && shade_en_ff |-> rsp_pixel_color[31:24] == 8'h00)
      else $error("shaded colour has a non-zero top byte");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      sc_ff[SHADE_QB-1].v |-> (q_r[15:8] == 8'h00) && (q_g[15:8] == 8'h00) &&
                              (q_b[15:8] == 8'h00))
      else $error("shading quotient exceeds one byte");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input held back with an empty output register");

endmodule
`default_nettype wire
